>>> src/retry_backoff_delay_macros.svh
// assertion macros for the retry backoff delay block
`ifndef RETRY_BACKOFF_DELAY_MACROS_SVH
`define RETRY_BACKOFF_DELAY_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define RBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rbd_pkg.sv
// shared types and constants for the retry backoff delay block
package rbd_pkg;

  localparam int unsigned ATTEMPT_W   = 6;
  localparam int unsigned RANDOM_W    = 32;
  localparam int unsigned DELAY_W     = 24;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned MUL_A_W     = 32;
  localparam int unsigned MUL_B_W     = 16;
  localparam int unsigned PROD_W      = MUL_A_W + MUL_B_W;
  localparam int unsigned BOUND_W     = 10;
  localparam int unsigned DIVISOR_W   = BOUND_W + 1;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam int unsigned DEF_MAX_ATTEMPT = 63;

  localparam logic [BOUND_W-1:0] JITTER_CAP = BOUND_W'(1000);
  localparam logic [BOUND_W-1:0] JITTER_MIN = BOUND_W'(1);

  // strategy codes
  localparam logic [1:0] STRAT_EXP = 2'd0;
  localparam logic [1:0] STRAT_LIN = 2'd1;
  localparam logic [1:0] STRAT_FIX = 2'd2;
  localparam logic [1:0] STRAT_FIB = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_STRATEGY = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GROWTH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_JITTER   = 3'd4;

  // reset values
  localparam logic [1:0]  RST_STRATEGY = STRAT_EXP;
  localparam logic [15:0] RST_INITIAL  = 16'd100;
  localparam logic [23:0] RST_MAX      = 24'd2000;
  localparam logic [11:0] RST_GROWTH   = 12'd512;
  localparam logic [15:0] RST_JITTER   = 16'd6554;

  // remainder unit status
  typedef struct packed {
    logic                 done;
    logic [DIVISOR_W-1:0] rem;
  } mod_res_t;

endpackage

>>> src/rbd_mod.sv
// bit-serial remainder unit, one dividend bit per cycle
module rbd_mod (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [rbd_pkg::RANDOM_W-1:0]        dividend,
  input  logic [rbd_pkg::DIVISOR_W-1:0]       divisor,
  output rbd_pkg::mod_res_t                   res
);

  localparam int unsigned CNT_W = $clog2(rbd_pkg::RANDOM_W);

  logic                              busy;
  logic                              done;
  logic [CNT_W-1:0]                  cnt;
  logic [rbd_pkg::RANDOM_W-1:0]      dq;
  logic [rbd_pkg::DIVISOR_W-1:0]     dv;
  logic [rbd_pkg::DIVISOR_W-1:0]     rem;
  logic [rbd_pkg::DIVISOR_W:0]       trial;
  logic [rbd_pkg::DIVISOR_W-1:0]     rem_next;

  always_comb begin
    trial = {rem, dq[rbd_pkg::RANDOM_W-1]};
    if (trial >= {1'b0, dv}) begin
      rem_next = rbd_pkg::DIVISOR_W'(trial - {1'b0, dv});
    end else begin
      rem_next = trial[rbd_pkg::DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= dividend;
        dv   <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dq  <= {dq[rbd_pkg::RANDOM_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(rbd_pkg::RANDOM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.rem  = rem;

endmodule

>>> src/retry_backoff_delay.sv
// retry backoff delay: base delay by strategy, jitter, clamp to maximum
// exponential runs one multiply per step on a shared 32x16 unit, fibonacci one add per step, then a multiply on it
// the jitter draw runs in a bit-serial remainder unit
// one request at a time; the next is taken once the result is in the output register
// synchronous reset: sequencer idle, output empty, registers to their reset values
module retry_backoff_delay #(
  parameter int unsigned MAX_ATTEMPT = rbd_pkg::DEF_MAX_ATTEMPT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [rbd_pkg::CFG_INDEX_W-1:0]     wr_index,
  input  logic [rbd_pkg::CFG_DATA_W-1:0]      wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rbd_pkg::ATTEMPT_W-1:0]       attempt,
  input  logic [rbd_pkg::RANDOM_W-1:0]        random_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rbd_pkg::DELAY_W-1:0]         backoff_ms
);

  localparam int unsigned ATT_MAX_FIELD = (1 << rbd_pkg::ATTEMPT_W) - 1;
  localparam int unsigned ATT_CAP = (MAX_ATTEMPT > ATT_MAX_FIELD) ? ATT_MAX_FIELD : MAX_ATTEMPT;
  localparam logic [rbd_pkg::ATTEMPT_W-1:0] ATT_CAP_V = rbd_pkg::ATTEMPT_W'(ATT_CAP);
  localparam int unsigned VW = rbd_pkg::VALUE_W;
  localparam int unsigned BW = rbd_pkg::BOUND_W;

  typedef enum logic [2:0] {
    IDLE, ITER, LINMUL, FIBMUL, JIT, MODW, ADJ, FIN
  } state_t;

  state_t state;

  logic [1:0]  strategy;
  logic [15:0] base_ms;
  logic [23:0] cap_ms;
  logic [11:0] growth_factor;
  logic [15:0] jitter_fraction;

  logic [rbd_pkg::ATTEMPT_W-1:0] cnt;
  logic [VW-1:0]                 acc;
  logic [VW-1:0]                 prev;
  logic [VW-1:0]                 d;
  logic [VW:0]                   fin;
  logic [BW-1:0]                 bound;
  logic [rbd_pkg::RANDOM_W-1:0]  rnd;

  logic [rbd_pkg::ATTEMPT_W-1:0] att_eff;
  logic [rbd_pkg::MUL_A_W-1:0]   mul_a;
  logic [rbd_pkg::MUL_B_W-1:0]   mul_b;
  logic [rbd_pkg::PROD_W-1:0]    prod;
  logic [VW-1:0]                 exp_next;
  logic [VW-1:0]                 prod_sat;
  logic [VW:0]                   fib_sum;
  logic [VW-1:0]                 fib_sat;
  logic [VW-1:0]                 bnd_raw;
  logic [BW-1:0]                 bnd_c;
  logic [BW-1:0]                 diff;
  logic [VW:0]                   adj;
  logic                          mod_start;
  rbd_pkg::mod_res_t             mres;
  logic                          accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != IDLE);
  assign att_eff  = (attempt > ATT_CAP_V) ? ATT_CAP_V : attempt;

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      ITER: begin
        mul_a = acc;
        mul_b = {4'b0, growth_factor};
      end
      LINMUL: begin
        mul_a = {{(rbd_pkg::MUL_A_W - rbd_pkg::ATTEMPT_W){1'b0}}, cnt};
        mul_b = base_ms;
      end
      FIBMUL: begin
        mul_a = acc;
        mul_b = base_ms;
      end
      default: begin
        mul_a = d;
        mul_b = jitter_fraction;
      end
    endcase
    prod = {{rbd_pkg::MUL_B_W{1'b0}}, mul_a} * {{rbd_pkg::MUL_A_W{1'b0}}, mul_b};
  end

  always_comb begin
    exp_next = (|prod[rbd_pkg::PROD_W-1:VW+8]) ? '1 : prod[VW+7:8];
    prod_sat = (|prod[rbd_pkg::PROD_W-1:VW]) ? '1 : prod[VW-1:0];
    fib_sum  = {1'b0, prev} + {1'b0, acc};
    fib_sat  = fib_sum[VW] ? '1 : fib_sum[VW-1:0];
    bnd_raw  = prod[rbd_pkg::PROD_W-1:16];
    if (bnd_raw > {{(VW - BW){1'b0}}, rbd_pkg::JITTER_CAP}) begin
      bnd_c = rbd_pkg::JITTER_CAP;
    end else if (bnd_raw < {{(VW - BW){1'b0}}, rbd_pkg::JITTER_MIN}) begin
      bnd_c = rbd_pkg::JITTER_MIN;
    end else begin
      bnd_c = bnd_raw[BW-1:0];
    end
  end

  // offset apply, negative sum floored at zero
  always_comb begin
    diff = bound - mres.rem[BW-1:0];
    if (mres.rem >= {1'b0, bound}) begin
      adj = {1'b0, d} + (VW + 1)'(mres.rem - {1'b0, bound});
    end else if (d >= {{(VW - BW){1'b0}}, diff}) begin
      adj = {1'b0, d - {{(VW - BW){1'b0}}, diff}};
    end else begin
      adj = '0;
    end
  end

  assign mod_start = (state == JIT) && (jitter_fraction != '0);

  rbd_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (rnd),
    .divisor  ({bnd_c, 1'b1}),
    .res      (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      out_valid        <= 1'b0;
      strategy         <= rbd_pkg::RST_STRATEGY;
      base_ms          <= rbd_pkg::RST_INITIAL;
      cap_ms           <= rbd_pkg::RST_MAX;
      growth_factor    <= rbd_pkg::RST_GROWTH;
      jitter_fraction  <= rbd_pkg::RST_JITTER;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          rbd_pkg::REG_STRATEGY: strategy         <= wr_data[1:0];
          rbd_pkg::REG_INITIAL:  base_ms          <= wr_data[15:0];
          rbd_pkg::REG_MAX:      cap_ms           <= wr_data[23:0];
          rbd_pkg::REG_GROWTH:   growth_factor    <= wr_data[11:0];
          rbd_pkg::REG_JITTER:   jitter_fraction  <= wr_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && (state != FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            rnd <= random_word;
            unique case (strategy)
              rbd_pkg::STRAT_EXP: begin
                acc   <= {16'b0, base_ms};
                cnt   <= (att_eff > 1) ? att_eff - 1'b1 : '0;
                state <= ITER;
              end
              rbd_pkg::STRAT_LIN: begin
                cnt   <= att_eff;
                state <= LINMUL;
              end
              rbd_pkg::STRAT_FIX: begin
                d     <= {16'b0, base_ms};
                state <= JIT;
              end
              default: begin
                prev  <= '0;
                acc   <= VW'(1);
                cnt   <= (att_eff > 1) ? att_eff - 1'b1 : '0;
                state <= ITER;
              end
            endcase
          end
        end
        ITER: begin
          if (cnt == '0) begin
            if (strategy == rbd_pkg::STRAT_EXP) begin
              d     <= acc;
              state <= JIT;
            end else begin
              state <= FIBMUL;
            end
          end else begin
            cnt <= cnt - 1'b1;
            if (strategy == rbd_pkg::STRAT_EXP) begin
              acc <= exp_next;
            end else begin
              prev <= acc;
              acc  <= fib_sat;
            end
          end
        end
        LINMUL, FIBMUL: begin
          d     <= prod_sat;
          state <= JIT;
        end
        JIT: begin
          if (jitter_fraction == '0) begin
            fin   <= {1'b0, d};
            state <= FIN;
          end else begin
            bound <= bnd_c;
            state <= MODW;
          end
        end
        MODW: begin
          if (mres.done) begin
            state <= ADJ;
          end
        end
        ADJ: begin
          fin   <= adj;
          state <= FIN;
        end
        FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            backoff_ms <= (fin > {9'b0, cap_ms}) ? cap_ms
                                                 : fin[rbd_pkg::DELAY_W-1:0];
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`include "retry_backoff_delay_macros.svh"

  `RBD_ASSERT_IMP(a_out_le_max, out_valid, backoff_ms <= cap_ms, "delay above maximum")
  `RBD_ASSERT_IMP(a_mod_done_state, mres.done, state == MODW, "remainder done out of turn")
  `RBD_ASSERT_IMP(a_bound_range, state == MODW, (bound >= rbd_pkg::JITTER_MIN) && (bound <= rbd_pkg::JITTER_CAP), "jitter bound out of range")
  `RBD_ASSERT_NXT(a_accept_busy, accept, state != IDLE, "request taken but sequencer idle")

endmodule
